### rtl/core/kdt_pkg.sv
`default_nettype none

package kdt_pkg;

  localparam int KEY_CHARS       = 6;
  localparam int KEY_W           = 48;
  localparam int PARTY_W         = 8;
  localparam int MODE_W          = 3;
  localparam int STATUS_W        = 3;
  localparam int DEF_MAX_ENTRIES = 16;

  localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_TAIL  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIND      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LIST      = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [KEY_W-1:0]   key_name;
    logic [PARTY_W-1:0] party_size;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    entry_name;
    logic [PARTY_W-1:0]  entry_party;
    logic                last;
  } rsp_t;

  typedef struct packed {
    logic push;
    rsp_t data;
  } res_push_t;

  // bytes after the first NUL are cleared
  function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] o;
    logic             hit;
    o   = '0;
    hit = 1'b0;
    for (int i = 0; i < KEY_CHARS; i++) begin
      if (k[KEY_W-1-8*i -: 8] == 8'h00) hit = 1'b1;
      if (!hit) o[KEY_W-1-8*i -: 8] = k[KEY_W-1-8*i -: 8];
    end
    return o;
  endfunction

endpackage

`default_nettype wire

### rtl/core/kdt_ram.sv
`default_nettype none

module kdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/kdt_seq.sv
`default_nettype none

module kdt_seq #(
  parameter int MAX_ENTRIES = kdt_pkg::DEF_MAX_ENTRIES
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  input  wire kdt_pkg::req_t                    in_data,
  output      logic                             busy,
  input  wire logic                             out_free,
  output      kdt_pkg::res_push_t               res,
  output      logic [$clog2(MAX_ENTRIES+1)-1:0] entry_count
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = kdt_pkg::KEY_W + kdt_pkg::PARTY_W;

  localparam kdt_pkg::rsp_t RSP_OK = '{status: kdt_pkg::ST_OK, entry_name: '0,
                                       entry_party: '0, last: 1'b1};

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SRD  = 9'b000000010,
    S_SCK  = 9'b000000100,
    S_MRD  = 9'b000001000,
    S_MWR  = 9'b000010000,
    S_PUT  = 9'b000100000,
    S_TRD  = 9'b001000000,
    S_TCK  = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_t;

  state_t                         state;
  logic [kdt_pkg::MODE_W-1:0]     mode;
  logic [kdt_pkg::KEY_W-1:0]      key;
  logic [kdt_pkg::PARTY_W-1:0]    party;
  logic [CW-1:0]                  idx;
  logic [CW-1:0]                  count;
  kdt_pkg::rsp_t                  rsp;

  logic                           we, re;
  logic [AW-1:0]                  waddr, raddr;
  logic [EW-1:0]                  wdata, rdata;
  logic [kdt_pkg::KEY_W-1:0]      rd_key;
  logic [kdt_pkg::PARTY_W-1:0]    rd_party;
  logic [CW-1:0]                  idx_inc;
  logic                           at_tail;
  logic                           front;

  assign rd_key   = rdata[EW-1 -: kdt_pkg::KEY_W];
  assign rd_party = rdata[kdt_pkg::PARTY_W-1:0];
  assign idx_inc  = idx + CW'(1);
  assign at_tail  = (idx_inc == count);
  assign front    = (mode == kdt_pkg::MODE_INS_FRONT);

  kdt_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = idx[AW-1:0];
    raddr = idx[AW-1:0];
    wdata = rdata;
    unique case (state)
      S_SRD, S_TRD: re = 1'b1;
      S_MRD: begin
        re    = 1'b1;
        raddr = front ? AW'(idx - CW'(1)) : idx_inc[AW-1:0];
      end
      S_MWR: we = 1'b1;
      S_PUT: begin
        we    = 1'b1;
        waddr = front ? '0 : count[AW-1:0];
        wdata = {key, party};
      end
      default: ;
    endcase
  end

  assign busy            = (state != S_IDLE);
  assign res.push        = (state == S_EMIT) && out_free;
  assign res.data        = rsp;
  assign entry_count     = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode  <= in_data.mode;
            key   <= kdt_pkg::canon_key(in_data.key_name);
            party <= in_data.party_size;
            idx   <= (in_data.mode == kdt_pkg::MODE_POP_TAIL) ? count - CW'(1) : '0;
            rsp   <= '{status: kdt_pkg::ST_EMPTY, entry_name: '0, entry_party: '0,
                       last: 1'b1};
            priority if (in_data.mode == kdt_pkg::MODE_INS_FRONT ||
                         in_data.mode == kdt_pkg::MODE_APPEND) begin
              state <= (count == '0) ? S_PUT : S_SRD;
            end else if (in_data.mode == kdt_pkg::MODE_POP_TAIL) begin
              state <= (count == '0) ? S_EMIT : S_TRD;
            end else if (in_data.mode == kdt_pkg::MODE_FIND ||
                         in_data.mode == kdt_pkg::MODE_DELETE) begin
              state <= (count == '0) ? S_EMIT : S_SRD;
            end else if (in_data.mode == kdt_pkg::MODE_LIST) begin
              state <= (count == '0) ? S_EMIT : S_TRD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SRD: state <= S_SCK;
        S_SCK: begin
          if (rd_key == key) begin
            priority if (mode == kdt_pkg::MODE_FIND) begin
              rsp   <= '{status: kdt_pkg::ST_OK, entry_name: rd_key,
                         entry_party: rd_party, last: 1'b1};
              state <= S_EMIT;
            end else if (mode == kdt_pkg::MODE_DELETE) begin
              rsp <= RSP_OK;
              if (at_tail) begin
                count <= count - CW'(1);
                state <= S_EMIT;
              end else begin
                state <= S_MRD;
              end
            end else begin
              rsp   <= '{status: kdt_pkg::ST_DUP, entry_name: '0, entry_party: '0,
                         last: 1'b1};
              state <= S_EMIT;
            end
          end else if (at_tail) begin
            priority if (mode == kdt_pkg::MODE_FIND || mode == kdt_pkg::MODE_DELETE) begin
              rsp   <= '{status: kdt_pkg::ST_NOTFOUND, entry_name: '0, entry_party: '0,
                         last: 1'b1};
              state <= S_EMIT;
            end else if (count == CW'(MAX_ENTRIES)) begin
              rsp   <= '{status: kdt_pkg::ST_FULL, entry_name: '0, entry_party: '0,
                         last: 1'b1};
              state <= S_EMIT;
            end else if (front) begin
              idx   <= count;
              state <= S_MRD;
            end else begin
              state <= S_PUT;
            end
          end else begin
            idx   <= idx_inc;
            state <= S_SRD;
          end
        end
        S_MRD: state <= S_MWR;
        S_MWR: begin
          if (front) begin
            idx   <= idx - CW'(1);
            state <= (idx == CW'(1)) ? S_PUT : S_MRD;
          end else begin
            idx <= idx_inc;
            if ((idx + CW'(2)) >= count) begin
              count <= count - CW'(1);
              state <= S_EMIT;
            end else begin
              state <= S_MRD;
            end
          end
        end
        S_PUT: begin
          count <= count + CW'(1);
          rsp   <= RSP_OK;
          state <= S_EMIT;
        end
        S_TRD: state <= S_TCK;
        S_TCK: begin
          rsp <= '{status: kdt_pkg::ST_OK, entry_name: rd_key, entry_party: rd_party,
                   last: (mode == kdt_pkg::MODE_POP_TAIL) || at_tail};
          if (mode == kdt_pkg::MODE_POP_TAIL) begin
            count <= count - CW'(1);
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (mode == kdt_pkg::MODE_LIST && !rsp.last) begin
              idx   <= idx_inc;
              state <= S_TRD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/keyed_deque_table.sv
// Ordered key table, one request at a time; entries in one RAM with a registered read.
// Each request is accepted; the key search then reads and checks entries in turn,
// entries are moved on insert at front or delete, the insert is written, and each
// listed entry or other result is emitted; an output stall holds the result.
// Search and moves go one entry at a time through the single RAM read port.
// Results go through an output register, so the next request can be taken
// while the last result waits. Reset (rst, sync) empties the table at once.
`default_nettype none

module keyed_deque_table #(
  parameter int MAX_ENTRIES = kdt_pkg::DEF_MAX_ENTRIES
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_stall,
  input  wire kdt_pkg::req_t in_data,
  output      logic          out_valid,
  input  wire logic          out_stall,
  output      kdt_pkg::rsp_t out_data
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  kdt_pkg::res_push_t res;
  logic               busy;
  logic               out_free;
  logic [CW-1:0]      entry_count;

  assign in_stall = busy;
  assign out_free = !out_valid || !out_stall;

  kdt_seq #(.MAX_ENTRIES(MAX_ENTRIES)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .busy       (busy),
    .out_free   (out_free),
    .res        (res),
    .entry_count(entry_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.push) out_data <= res.data;
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.push |-> (!out_valid || !out_stall))
    else $error("result pushed over a held result");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.mode <= kdt_pkg::MODE_LIST) |=> in_stall)
    else $error("request accepted without going busy");
`endif

endmodule

`default_nettype wire
